// ----- sv/apu2n_pkg.sv -----
`default_nettype none

package apu2n_pkg;

    // sample and accumulator widths
    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 32;
    localparam int COEF_W   = 16;

    // filter coefficients, 16-bit signed
    localparam logic signed [COEF_W-1:0] AP_EVEN_A = 16'sd4280;
    localparam logic signed [COEF_W-1:0] AP_EVEN_B = -16'sd31809;
    localparam logic signed [COEF_W-1:0] AP_ODD_A  = 16'sd16295;
    localparam logic signed [COEF_W-1:0] AP_ODD_B  = -16'sd11521;
    localparam logic signed [COEF_W-1:0] NOTCH_B1  = 16'sd7864;
    localparam logic signed [COEF_W-1:0] NOTCH_A1  = -16'sd3604;
    localparam logic signed [COEF_W-1:0] NOTCH_A2  = 16'sd13107;
    localparam logic signed [COEF_W-1:0] OUT_GAIN  = 16'sd28508;
    localparam logic signed [ACC_W-1:0]  ROUND_OFS = 32'sd256;

    // number of filter state words and index width
    localparam int NUM_ST = 6;
    localparam int ST_IW  = $clog2(NUM_ST);

    // alu operations
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MAC = 2'd2;

    // operand sources
    localparam logic [2:0] OPD_ZERO = 3'd0;
    localparam logic [2:0] OPD_X    = 3'd1;
    localparam logic [2:0] OPD_Y    = 3'd2;
    localparam logic [2:0] OPD_T    = 3'd3;
    localparam logic [2:0] OPD_P    = 3'd4;
    localparam logic [2:0] OPD_Q    = 3'd5;
    localparam logic [2:0] OPD_ST   = 3'd6;
    localparam logic [2:0] OPD_RND  = 3'd7;

    // coefficient selection
    localparam logic [2:0] CF_APA  = 3'd0;
    localparam logic [2:0] CF_APB  = 3'd1;
    localparam logic [2:0] CF_A2   = 3'd2;
    localparam logic [2:0] CF_A1   = 3'd3;
    localparam logic [2:0] CF_B1   = 3'd4;
    localparam logic [2:0] CF_GAIN = 3'd5;

    // state word role within the current branch
    localparam logic [1:0] ROLE_AP0   = 2'd0;
    localparam logic [1:0] ROLE_AP1   = 2'd1;
    localparam logic [1:0] ROLE_OWN   = 2'd2;
    localparam logic [1:0] ROLE_OTHER = 2'd3;

    // destinations
    localparam logic [2:0] DST_Y   = 3'd0;
    localparam logic [2:0] DST_T   = 3'd1;
    localparam logic [2:0] DST_P   = 3'd2;
    localparam logic [2:0] DST_Q   = 3'd3;
    localparam logic [2:0] DST_ST  = 3'd4;
    localparam logic [2:0] DST_OUT = 3'd5;

    // steps per branch
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = 4'd12;

    // one micro-operation of the branch program
    typedef struct packed {
        logic [1:0] op;
        logic [2:0] a_sel;
        logic [2:0] b_sel;
        logic [2:0] coef;
        logic [1:0] role;
        logic [2:0] dest;
    } uop_t;

    // branch program: two allpass sections, notch half, output gain
    function automatic uop_t ucode(input logic [STEP_W-1:0] step);
        uop_t u;
        u = '{op: OP_ADD, a_sel: OPD_ZERO, b_sel: OPD_ZERO, coef: CF_APA,
              role: ROLE_AP0, dest: DST_Y};
        unique case (step)
            4'd0:  u = '{OP_SUB, OPD_X,    OPD_ST, CF_APA,  ROLE_AP0,   DST_Y};
            4'd1:  u = '{OP_MAC, OPD_ZERO, OPD_Y,  CF_APA,  ROLE_AP0,   DST_T};
            4'd2:  u = '{OP_ADD, OPD_ST,   OPD_T,  CF_APA,  ROLE_AP0,   DST_P};
            4'd3:  u = '{OP_ADD, OPD_X,    OPD_T,  CF_APA,  ROLE_AP0,   DST_ST};
            4'd4:  u = '{OP_SUB, OPD_P,    OPD_ST, CF_APB,  ROLE_AP1,   DST_Y};
            4'd5:  u = '{OP_MAC, OPD_Y,    OPD_Y,  CF_APB,  ROLE_AP1,   DST_T};
            4'd6:  u = '{OP_ADD, OPD_ST,   OPD_T,  CF_APB,  ROLE_AP1,   DST_Q};
            4'd7:  u = '{OP_ADD, OPD_P,    OPD_T,  CF_APB,  ROLE_AP1,   DST_ST};
            4'd8:  u = '{OP_MAC, OPD_Q,    OPD_ST, CF_A2,   ROLE_OWN,   DST_Q};
            4'd9:  u = '{OP_MAC, OPD_Q,    OPD_ST, CF_A1,   ROLE_OTHER, DST_Q};
            4'd10: u = '{OP_MAC, OPD_Q,    OPD_ST, CF_B1,   ROLE_OTHER, DST_P};
            4'd11: u = '{OP_SUB, OPD_Q,    OPD_ST, CF_B1,   ROLE_OWN,   DST_ST};
            4'd12: u = '{OP_MAC, OPD_RND,  OPD_P,  CF_GAIN, ROLE_OWN,   DST_OUT};
            default: u = '{OP_ADD, OPD_ZERO, OPD_ZERO, CF_APA, ROLE_AP0, DST_Y};
        endcase
        return u;
    endfunction

    // map a role to a state word; odd branch uses words 2..3 and swaps the notch pair
    function automatic logic [ST_IW-1:0] st_index(input logic [1:0] role,
                                                  input logic odd);
        logic [ST_IW-1:0] idx;
        idx = '0;
        unique case (role)
            ROLE_AP0:   idx = odd ? 3'd2 : 3'd0;
            ROLE_AP1:   idx = odd ? 3'd3 : 3'd1;
            ROLE_OWN:   idx = odd ? 3'd4 : 3'd5;
            ROLE_OTHER: idx = odd ? 3'd5 : 3'd4;
            default:    idx = '0;
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

// ----- sv/apu2n_alu.sv -----
`default_nettype none

module apu2n_alu (
    input  wire logic [1:0]                             op,
    input  wire logic signed [apu2n_pkg::ACC_W-1:0]     opd_a,
    input  wire logic signed [apu2n_pkg::ACC_W-1:0]     opd_b,
    input  wire logic signed [apu2n_pkg::COEF_W-1:0]    coef,
    output logic signed [apu2n_pkg::ACC_W-1:0]          res
);
    import apu2n_pkg::*;

    logic signed [ACC_W+COEF_W-1:0] prod;

    // 32x16 product, upper 32 bits give the floor of the product over 2^16
    assign prod = opd_b * coef;

    // shared add / subtract / multiply-accumulate, wrapping at 32 bits
    always_comb begin
        case (op)
            OP_ADD:  res = opd_a + opd_b;
            OP_SUB:  res = opd_a - opd_b;
            OP_MAC:  res = opd_a + prod[ACC_W+COEF_W-1:COEF_W];
            default: res = opd_a;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/allpass_upsample_2x_notch.sv -----
`default_nettype none
// one shared 32x16 multiply-accumulate unit runs 13 micro-steps for each of the two branches;
// the input is accepted in the idle state and the finished pair is handed over in the flush state
// the input is not ready while an item is in flight; a finished pair waits in the output register
// reset (synchronous, active low) clears control state and the six filter state words

module allpass_upsample_2x_notch (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // tdata: sample [15:0]
    input  wire logic [15:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: even_sample [15:0], odd_sample [31:16]
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready
);
    import apu2n_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [STEP_W-1:0]         step_reg;
    logic                      odd_reg;
    logic                      last_reg;
    logic signed [ACC_W-1:0]   x_reg, y_reg, t_reg, p_reg, q_reg;
    logic signed [ACC_W-1:0]   filt_reg [NUM_ST];
    logic [SAMPLE_W-1:0]       even_reg, odd_w_reg;

    uop_t                      uop;
    logic [ST_IW-1:0]          st_idx;
    logic signed [ACC_W-1:0]   st_val;
    logic signed [ACC_W-1:0]   opd_a, opd_b, alu_res;
    logic signed [COEF_W-1:0]  coef;
    logic signed [ACC_W-10:0]  fin_shift;
    logic [SAMPLE_W-1:0]       fin_sat;
    logic                      out_free;

    // decode the current micro-step
    assign uop    = ucode(step_reg);
    assign st_idx = st_index(uop.role, odd_reg);
    assign st_val = filt_reg[st_idx];

    // operand selection
    function automatic logic signed [ACC_W-1:0] pick(
        input logic [2:0] sel, input logic signed [ACC_W-1:0] x,
        input logic signed [ACC_W-1:0] y, input logic signed [ACC_W-1:0] t,
        input logic signed [ACC_W-1:0] p, input logic signed [ACC_W-1:0] q,
        input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] v;
        v = '0;
        case (sel)
            OPD_ZERO: v = '0;
            OPD_X:    v = x;
            OPD_Y:    v = y;
            OPD_T:    v = t;
            OPD_P:    v = p;
            OPD_Q:    v = q;
            OPD_ST:   v = s;
            OPD_RND:  v = ROUND_OFS;
            default:  v = '0;
        endcase
        return v;
    endfunction

    assign opd_a = pick(uop.a_sel, x_reg, y_reg, t_reg, p_reg, q_reg, st_val);
    assign opd_b = pick(uop.b_sel, x_reg, y_reg, t_reg, p_reg, q_reg, st_val);

    // coefficient selection, allpass pair depends on the branch
    always_comb begin
        case (uop.coef)
            CF_APA:  coef = odd_reg ? AP_ODD_A : AP_EVEN_A;
            CF_APB:  coef = odd_reg ? AP_ODD_B : AP_EVEN_B;
            CF_A2:   coef = NOTCH_A2;
            CF_A1:   coef = NOTCH_A1;
            CF_B1:   coef = NOTCH_B1;
            CF_GAIN: coef = OUT_GAIN;
            default: coef = '0;
        endcase
    end

    apu2n_alu u_alu (
        .op    (uop.op),
        .opd_a (opd_a),
        .opd_b (opd_b),
        .coef  (coef),
        .res   (alu_res)
    );

    // output shift by 9 and saturation to 16 bits
    assign fin_shift = alu_res[ACC_W-1:9];
    always_comb begin
        if (fin_shift[ACC_W-10:SAMPLE_W-1] == '0 ||
            fin_shift[ACC_W-10:SAMPLE_W-1] == '1) begin
            fin_sat = fin_shift[SAMPLE_W-1:0];
        end else if (fin_shift[ACC_W-10]) begin
            fin_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            fin_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_axis_tvalid) state_next = ST_RUN;
            ST_RUN:   if (step_reg == LAST_STEP && odd_reg) state_next = ST_FLUSH;
            ST_FLUSH: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            odd_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE) begin
                step_reg <= '0;
                odd_reg  <= 1'b0;
            end else if (state_reg == ST_RUN) begin
                if (step_reg == LAST_STEP) begin
                    step_reg <= '0;
                    odd_reg  <= !odd_reg;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    // input capture and working registers
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            x_reg    <= {{(ACC_W-SAMPLE_W-10){s_axis_tdata[SAMPLE_W-1]}},
                         s_axis_tdata, 10'b0};
            last_reg <= s_axis_tlast;
        end
        if (state_reg == ST_RUN) begin
            case (uop.dest)
                DST_Y: y_reg <= alu_res;
                DST_T: t_reg <= alu_res;
                DST_P: p_reg <= alu_res;
                DST_Q: q_reg <= alu_res;
                DST_OUT: begin
                    if (odd_reg) odd_w_reg <= fin_sat;
                    else         even_reg  <= fin_sat;
                end
                default: ;
            endcase
        end
    end

    // filter state words, cleared after the last sample of a sound
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ST; i++) filt_reg[i] <= '0;
        end else if (state_reg == ST_RUN) begin
            if (step_reg == LAST_STEP && odd_reg && last_reg) begin
                for (int i = 0; i < NUM_ST; i++) filt_reg[i] <= '0;
            end else if (uop.dest == DST_ST) begin
                filt_reg[st_idx] <= alu_res;
            end
        end
    end

    // output register, freed by the downstream transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tvalid <= 1'b0;
        end else if (state_reg == ST_FLUSH && out_free) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FLUSH && out_free) begin
            m_axis_tdata <= {odd_w_reg, even_reg};
            m_axis_tlast <= last_reg;
        end
    end

endmodule

`default_nettype wire
